/* hdl/wrm_pkg.sv */
// ----------------------------------------------------------------------------
// wrm_pkg
// Shared constants and types for the windowed robust mean jitter block.
// ----------------------------------------------------------------------------
`default_nettype none

package wrm_pkg;

  // window geometry
  localparam int WINDOW = 16;
  localparam int IDX_W  = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int PASS_W = $clog2(WINDOW + 1);

  // field widths
  localparam int TIME_W = 48;
  localparam int OFF_W  = 24;
  localparam int OCNT_W = 5;

  // datapath widths
  localparam int DIF_W  = TIME_W + 1;
  localparam int SUM_W  = OFF_W + IDX_W;
  localparam int AD_W   = OFF_W;
  localparam int MSQ_W  = 2 * AD_W;
  localparam int SQ_W   = MSQ_W + IDX_W;
  localparam int DEV_W  = AD_W;
  localparam int RR_W   = DEV_W + 3;
  localparam int ITER_W = $clog2(SUM_W);

  // saturation limits of the stored offset
  localparam logic signed [DIF_W-1:0] OFF_MAX = DIF_W'((64'sd1 <<< (OFF_W - 1)) - 64'sd1);
  localparam logic signed [DIF_W-1:0] OFF_MIN = DIF_W'(-(64'sd1 <<< (OFF_W - 1)));

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_PICK,
    S_SUM,
    S_SQ,
    S_SQRT,
    S_INL,
    S_DIV,
    S_SIGN,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

/* hdl/wrm_if.sv */
// ----------------------------------------------------------------------------
// wrm_in_if / wrm_out_if
// Valid/ready channels carrying click items and jitter result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface wrm_in_if;
  logic                          valid;
  logic                          ready;
  logic [wrm_pkg::TIME_W-1:0]    click_time;
  logic [wrm_pkg::TIME_W-1:0]    prior_beat_time;
  logic [wrm_pkg::TIME_W-1:0]    coming_beat_time;

  modport source (output valid, click_time, prior_beat_time, coming_beat_time,
                  input ready);
  modport sink   (input valid, click_time, prior_beat_time, coming_beat_time,
                  output ready);
endinterface

interface wrm_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [wrm_pkg::OFF_W-1:0]  chosen_offset;
  logic signed [wrm_pkg::OFF_W-1:0]  window_mean;
  logic        [wrm_pkg::DEV_W-1:0]  deviation;
  logic        [wrm_pkg::OCNT_W-1:0] inlier_count;
  logic signed [wrm_pkg::OFF_W-1:0]  inlier_mean;

  modport source (output valid, chosen_offset, window_mean, deviation,
                  inlier_count, inlier_mean, input ready);
  modport sink   (input valid, chosen_offset, window_mean, deviation,
                  inlier_count, inlier_mean, output ready);
endinterface

`default_nettype wire

/* hdl/wrm_ram.sv */
// ----------------------------------------------------------------------------
// wrm_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hdl/windowed_robust_mean_jitter.sv */
// ----------------------------------------------------------------------------
// windowed_robust_mean_jitter
// Click timing jitter: keeps a 16-entry ring of beat offsets and reports the
// window mean, deviation and the mean of entries within one deviation.
// ----------------------------------------------------------------------------
// Each item passes through these steps in order: forming and picking the
// offset; three passes over the ring through the RAM's single read port
// (sum, squared deviation, inlier scan); a bit-serial square root; a
// restoring divider plus one sign step; an output step and an idle step.
// When there are no inliers the divider and sign step are skipped. One item
// is worked on at a time. A new item is taken once the previous result sits
// in the output register. A result still waiting there holds the next one
// in the output step until it is taken.
// The ring reads as zero after reset through per-entry valid bits.
`default_nettype none

module windowed_robust_mean_jitter (
  input wire logic   clk,
  input wire logic   rst_n,
  wrm_in_if.sink     in_ch,
  wrm_out_if.source  out_ch
);

  import wrm_pkg::*;

  // control state
  state_t                     state_r, state_nxt;
  logic [IDX_W-1:0]           head_r, head_nxt;
  logic [WINDOW-1:0]          vld_r, vld_nxt;
  logic [PASS_W-1:0]          iss_r, iss_nxt;
  logic                       p1_r, p1_nxt, p2_r, p2_nxt, p3_r, p3_nxt;
  logic [IDX_W-1:0]           raddr_r, raddr_nxt;
  logic [ITER_W-1:0]          it_r, it_nxt;
  logic                       ovld_r, ovld_nxt;

  // datapath
  logic [TIME_W-1:0]          click_r, click_nxt, prior_r, prior_nxt, coming_r, coming_nxt;
  logic signed [DIF_W-1:0]    a_r, a_nxt, b_r, b_nxt;
  logic signed [OFF_W-1:0]    pick_r, pick_nxt;
  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic signed [OFF_W-1:0]    mean_r, mean_nxt;
  logic [AD_W-1:0]            ad_r, ad_nxt;
  logic [MSQ_W-1:0]           prod_r, prod_nxt;
  logic [SQ_W-1:0]            sq_r, sq_nxt;
  logic [MSQ_W-1:0]           m_r, m_nxt;
  logic [DEV_W-1:0]           root_r, root_nxt;
  logic [RR_W-1:0]            rem_r, rem_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic signed [SUM_W-1:0]    isum_r, isum_nxt;
  logic                       neg_r, neg_nxt;
  logic [SUM_W-1:0]           num_r, num_nxt;
  logic [CNT_W-1:0]           drem_r, drem_nxt;
  logic signed [OFF_W-1:0]    imean_r, imean_nxt;

  // output register
  logic signed [OFF_W-1:0]    o_pick_r, o_pick_nxt, o_mean_r, o_mean_nxt;
  logic signed [OFF_W-1:0]    o_imean_r, o_imean_nxt;
  logic [DEV_W-1:0]           o_dev_r, o_dev_nxt;
  logic [OCNT_W-1:0]          o_cnt_r, o_cnt_nxt;

  // RAM port
  logic                       ram_we, ram_re;
  logic [OFF_W-1:0]           ram_q;

  // combinational helpers
  logic                       in_acc;
  logic                       pass_done;
  logic signed [OFF_W-1:0]    ent;
  logic signed [OFF_W:0]      dif;
  logic [OFF_W:0]             dif_abs;
  logic signed [DIF_W:0]      ab_sum;
  logic signed [DIF_W-1:0]    pick_raw;
  logic signed [OFF_W-1:0]    pick_sat;
  logic [RR_W-1:0]            rem_sh, trial;
  logic [CNT_W:0]             drem_sh;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  // ring storage
  wrm_ram #(.WIDTH(OFF_W), .DEPTH(WINDOW)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head_r),
    .wdata (pick_sat),
    .re    (ram_re),
    .raddr (iss_r[IDX_W-1:0]),
    .rdata (ram_q)
  );

  // entry read back; unwritten entries read as zero
  assign ent     = vld_r[raddr_r] ? $signed(ram_q) : '0;
  assign dif     = {ent[OFF_W-1], ent} - {mean_r[OFF_W-1], mean_r};
  assign dif_abs = dif[OFF_W] ? (OFF_W+1)'(-dif) : dif;

  // offset selection and saturation
  assign ab_sum   = {a_r[DIF_W-1], a_r} + {b_r[DIF_W-1], b_r};
  assign pick_raw = ab_sum[DIF_W] ? a_r : b_r;
  always_comb begin
    if (pick_raw > OFF_MAX) begin
      pick_sat = OFF_W'(OFF_MAX);
    end else if (pick_raw < OFF_MIN) begin
      pick_sat = OFF_W'(OFF_MIN);
    end else begin
      pick_sat = pick_raw[OFF_W-1:0];
    end
  end

  // square root and divider steps
  assign rem_sh  = {rem_r[RR_W-3:0], m_r[MSQ_W-1:MSQ_W-2]};
  assign trial   = {1'b0, root_r, 2'b01};
  assign drem_sh = {drem_r, num_r[SUM_W-1]};

  assign pass_done = (iss_r == PASS_W'(WINDOW)) && !p1_r && !p2_r && !p3_r;

  // next state and datapath
  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    vld_nxt    = vld_r;
    iss_nxt    = iss_r;
    p1_nxt     = 1'b0;
    p2_nxt     = 1'b0;
    p3_nxt     = 1'b0;
    raddr_nxt  = raddr_r;
    it_nxt     = it_r;
    ovld_nxt   = ovld_r && !out_ch.ready;
    click_nxt  = click_r;
    prior_nxt  = prior_r;
    coming_nxt = coming_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    pick_nxt   = pick_r;
    sum_nxt    = sum_r;
    mean_nxt   = mean_r;
    ad_nxt     = ad_r;
    prod_nxt   = prod_r;
    sq_nxt     = sq_r;
    m_nxt      = m_r;
    root_nxt   = root_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    isum_nxt   = isum_r;
    neg_nxt    = neg_r;
    num_nxt    = num_r;
    drem_nxt   = drem_r;
    imean_nxt  = imean_r;
    o_pick_nxt  = o_pick_r;
    o_mean_nxt  = o_mean_r;
    o_dev_nxt   = o_dev_r;
    o_cnt_nxt   = o_cnt_r;
    o_imean_nxt = o_imean_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;

    // ring read issue, shared by the three passes
    if ((state_r == S_SUM || state_r == S_SQ || state_r == S_INL) &&
        iss_r != PASS_W'(WINDOW)) begin
      ram_re    = 1'b1;
      iss_nxt   = iss_r + 1'b1;
      p1_nxt    = 1'b1;
      raddr_nxt = iss_r[IDX_W-1:0];
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          click_nxt  = in_ch.click_time;
          prior_nxt  = in_ch.prior_beat_time;
          coming_nxt = in_ch.coming_beat_time;
          state_nxt  = S_DIFF;
        end
      end
      S_DIFF: begin
        a_nxt     = $signed({1'b0, click_r}) - $signed({1'b0, prior_r});
        b_nxt     = $signed({1'b0, click_r}) - $signed({1'b0, coming_r});
        state_nxt = S_PICK;
      end
      S_PICK: begin
        ram_we          = 1'b1;
        vld_nxt[head_r] = 1'b1;
        head_nxt        = (head_r == IDX_W'(WINDOW - 1)) ? '0 : head_r + 1'b1;
        pick_nxt        = pick_sat;
        iss_nxt         = '0;
        sum_nxt         = '0;
        state_nxt       = S_SUM;
      end
      S_SUM: begin
        if (p1_r) begin
          sum_nxt = sum_r + SUM_W'(ent);
        end
        if (pass_done) begin
          mean_nxt  = sum_r[SUM_W-1:IDX_W];
          iss_nxt   = '0;
          sq_nxt    = '0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        // abs diff -> square -> accumulate
        p2_nxt = p1_r;
        p3_nxt = p2_r;
        if (p1_r) begin
          ad_nxt = dif_abs[AD_W-1:0];
        end
        if (p2_r) begin
          prod_nxt = ad_r * ad_r;
        end
        if (p3_r) begin
          sq_nxt = sq_r + SQ_W'(prod_r);
        end
        if (pass_done) begin
          m_nxt     = sq_r[SQ_W-1:IDX_W];
          root_nxt  = '0;
          rem_nxt   = '0;
          it_nxt    = '0;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        // one result bit per cycle
        if (rem_sh >= trial) begin
          rem_nxt  = rem_sh - trial;
          root_nxt = {root_r[DEV_W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh;
          root_nxt = {root_r[DEV_W-2:0], 1'b0};
        end
        m_nxt  = {m_r[MSQ_W-3:0], 2'b00};
        it_nxt = it_r + 1'b1;
        if (it_r == ITER_W'(DEV_W - 1)) begin
          iss_nxt   = '0;
          cnt_nxt   = '0;
          isum_nxt  = '0;
          state_nxt = S_INL;
        end
      end
      S_INL: begin
        if (p1_r && dif_abs < (OFF_W+1)'(root_r)) begin
          cnt_nxt  = cnt_r + 1'b1;
          isum_nxt = isum_r + SUM_W'(ent);
        end
        if (pass_done) begin
          if (cnt_r == '0) begin
            imean_nxt = mean_r;
            state_nxt = S_OUT;
          end else begin
            neg_nxt   = isum_r[SUM_W-1];
            num_nxt   = isum_r[SUM_W-1] ? SUM_W'(-isum_r) : isum_r;
            drem_nxt  = '0;
            it_nxt    = '0;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        // restoring divide, quotient shifts into num
        if (drem_sh >= {1'b0, cnt_r}) begin
          drem_nxt = CNT_W'(drem_sh - {1'b0, cnt_r});
          num_nxt  = {num_r[SUM_W-2:0], 1'b1};
        end else begin
          drem_nxt = drem_sh[CNT_W-1:0];
          num_nxt  = {num_r[SUM_W-2:0], 1'b0};
        end
        it_nxt = it_r + 1'b1;
        if (it_r == ITER_W'(SUM_W - 1)) begin
          state_nxt = S_SIGN;
        end
      end
      S_SIGN: begin
        imean_nxt = neg_r ? OFF_W'(-num_r) : OFF_W'(num_r);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ovld_r || out_ch.ready) begin
          ovld_nxt    = 1'b1;
          o_pick_nxt  = pick_r;
          o_mean_nxt  = mean_r;
          o_dev_nxt   = root_r;
          o_cnt_nxt   = OCNT_W'(cnt_r);
          o_imean_nxt = imean_r;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      vld_r   <= '0;
      iss_r   <= '0;
      p1_r    <= 1'b0;
      p2_r    <= 1'b0;
      p3_r    <= 1'b0;
      it_r    <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      vld_r   <= vld_nxt;
      iss_r   <= iss_nxt;
      p1_r    <= p1_nxt;
      p2_r    <= p2_nxt;
      p3_r    <= p3_nxt;
      it_r    <= it_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    raddr_r   <= raddr_nxt;
    click_r   <= click_nxt;
    prior_r   <= prior_nxt;
    coming_r  <= coming_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    pick_r    <= pick_nxt;
    sum_r     <= sum_nxt;
    mean_r    <= mean_nxt;
    ad_r      <= ad_nxt;
    prod_r    <= prod_nxt;
    sq_r      <= sq_nxt;
    m_r       <= m_nxt;
    root_r    <= root_nxt;
    rem_r     <= rem_nxt;
    cnt_r     <= cnt_nxt;
    isum_r    <= isum_nxt;
    neg_r     <= neg_nxt;
    num_r     <= num_nxt;
    drem_r    <= drem_nxt;
    imean_r   <= imean_nxt;
    o_pick_r  <= o_pick_nxt;
    o_mean_r  <= o_mean_nxt;
    o_dev_r   <= o_dev_nxt;
    o_cnt_r   <= o_cnt_nxt;
    o_imean_r <= o_imean_nxt;
  end

  // result channel
  assign out_ch.valid         = ovld_r;
  assign out_ch.chosen_offset = o_pick_r;
  assign out_ch.window_mean   = o_mean_r;
  assign out_ch.deviation     = o_dev_r;
  assign out_ch.inlier_count  = o_cnt_r;
  assign out_ch.inlier_mean   = o_imean_r;

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("item accepted while a previous item was in flight");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r |-> (o_cnt_r <= OCNT_W'(WINDOW)))
    else $error("inlier count exceeds window");

  a_zero_dev_no_inliers: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && o_dev_r == '0) |-> (o_cnt_r == '0))
    else $error("inliers reported with zero deviation");

  a_ring_write_once: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (state_r == S_SUM) && !ram_we)
    else $error("ring written outside the pick step");

endmodule

`default_nettype wire

/* dv/wrm_tb_if.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wrm_tb_if
// Interface instances for the windowed robust mean jitter testbench come from
// the design's own interface file; this file only holds shared test types.
// ----------------------------------------------------------------------------
package wrm_tb_pkg;
  import wrm_pkg::*;

  // one click item
  typedef struct packed {
    logic [TIME_W-1:0] click;
    logic [TIME_W-1:0] prior;
    logic [TIME_W-1:0] coming;
  } click_item_t;

  // one jitter result item
  typedef struct packed {
    logic signed [OFF_W-1:0]  offset;
    logic signed [OFF_W-1:0]  mean;
    logic        [DEV_W-1:0]  dev;
    logic        [OCNT_W-1:0] cnt;
    logic signed [OFF_W-1:0]  imean;
  } jitter_t;
endpackage

/* dv/windowed_robust_mean_jitter_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// windowed_robust_mean_jitter_test
// Drives click items with random gaps and output stalls, predicts each jitter
// result from a local ring model and compares each whole result with it.
// ----------------------------------------------------------------------------
module windowed_robust_mean_jitter_test;
  import wrm_pkg::*;
  import wrm_tb_pkg::*;

  localparam longint CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  wrm_in_if  in_ch ();
  wrm_out_if out_ch ();

  windowed_robust_mean_jitter u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  click_item_t pending_clicks[$];
  jitter_t     expected_jitter[$];
  logic signed [OFF_W-1:0] ring_model[WINDOW];
  int unsigned head_model;
  int unsigned errors;
  int unsigned click_gap;
  int unsigned stall_left;
  bit          stim_done;
  longint      cycles;

  // jitter for one click, updating the ring model
  function automatic jitter_t jitter_of(click_item_t c);
    jitter_t r;
    longint to_prior, to_coming, pick, sum, mean, isum, d;
    longint unsigned sq, dev, ad;
    int cnt;
    to_prior  = longint'({16'd0, c.click}) - longint'({16'd0, c.prior});
    to_coming = longint'({16'd0, c.click}) - longint'({16'd0, c.coming});
    pick = (-to_prior > to_coming) ? to_prior : to_coming;
    if (pick > 64'sd8388607) pick = 64'sd8388607;
    if (pick < -64'sd8388608) pick = -64'sd8388608;
    ring_model[head_model] = pick[OFF_W-1:0];
    head_model = (head_model + 1) % WINDOW;
    sum = 0;
    for (int i = 0; i < WINDOW; i++) sum += longint'(ring_model[i]);
    mean = sum / WINDOW;
    if (sum % WINDOW != 0 && sum < 0) mean -= 1;
    sq = 0;
    for (int i = 0; i < WINDOW; i++) begin
      d = longint'(ring_model[i]) - mean;
      ad = (d < 0) ? -d : d;
      sq += ad * ad;
    end
    sq = sq / WINDOW;
    dev = 0;
    // floor square root by binary search
    for (int b = 31; b >= 0; b--)
      if ((dev | (64'd1 << b)) * (dev | (64'd1 << b)) <= sq) dev |= 64'd1 << b;
    cnt = 0;
    isum = 0;
    for (int i = 0; i < WINDOW; i++) begin
      d = longint'(ring_model[i]) - mean;
      ad = (d < 0) ? -d : d;
      if (ad < dev) begin
        cnt++;
        isum += longint'(ring_model[i]);
      end
    end
    r.offset = pick[OFF_W-1:0];
    r.mean   = mean[OFF_W-1:0];
    r.dev    = dev[DEV_W-1:0];
    r.cnt    = cnt[OCNT_W-1:0];
    r.imean  = (cnt == 0) ? mean[OFF_W-1:0] : OFF_W'(isum / cnt);
    return r;
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    return TIME_W'({$urandom(), $urandom()});
  endfunction

  // stimulus
  initial begin
    click_item_t c;
    logic [TIME_W-1:0] base;
    logic [TIME_W-1:0] all1;
    all1 = '1;
    // directed: extremes, saturation both ways, order swaps, a run of equal items
    pending_clicks.push_back('{'0, '0, '0});
    pending_clicks.push_back('{all1, all1, all1});
    pending_clicks.push_back('{all1, '0, '0});
    pending_clicks.push_back('{'0, all1, all1});
    pending_clicks.push_back('{48'd100, 48'd200, 48'd50});
    pending_clicks.push_back('{48'd8388607, 48'd0, 48'd16777214});
    pending_clicks.push_back('{48'd8388608, 48'd0, 48'd16777216});
    pending_clicks.push_back('{48'd0, 48'd8388608, 48'd8388608});
    pending_clicks.push_back('{48'd0, 48'd8388609, 48'd8388609});
    pending_clicks.push_back('{48'd1000, 48'd990, 48'd1010});
    for (int i = 0; i < 15; i++)
      pending_clicks.push_back('{48'd5000, 48'd4990, 48'd6000});
    // random: mostly realistic beat spacing, some wide-open noise
    for (int i = 0; i < 1600; i++) begin
      if ($urandom_range(0, 9) < 2) begin
        c.click = rand_time();
        c.prior = rand_time();
        c.coming = rand_time();
      end else begin
        base = rand_time() >> 1;
        c.prior = base;
        c.coming = base + $urandom_range(1, 2000000);
        c.click = base + $urandom_range(0, 2000000) - $urandom_range(0, 100000);
      end
      pending_clicks.push_back(c);
    end
  end

  // reset, then wait for drain
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done && expected_jitter.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("windowed_robust_mean_jitter: match");
    end else begin
      $display("windowed_robust_mean_jitter: mismatch");
    end
    $finish;
  end

  // timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("windowed_robust_mean_jitter: mismatch");
      $finish;
    end
  end

  // driver
  initial begin
    in_ch.valid = 1'b0;
    in_ch.click_time = '0;
    in_ch.prior_beat_time = '0;
    in_ch.coming_beat_time = '0;
    out_ch.ready = 1'b0;
    errors = 0;
    head_model = 0;
    click_gap = 0;
    stall_left = 0;
    stim_done = 1'b0;
    cycles = 0;
    for (int i = 0; i < WINDOW; i++) ring_model[i] = '0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_jitter.push_back(jitter_of('{in_ch.click_time, in_ch.prior_beat_time,
                                              in_ch.coming_beat_time}));
        click_gap = $urandom_range(0, 3);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (click_gap == 0 && pending_clicks.size() > 0) begin
          click_item_t c;
          c = pending_clicks.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.click_time <= c.click;
          in_ch.prior_beat_time <= c.prior;
          in_ch.coming_beat_time <= c.coming;
        end else begin
          in_ch.valid <= 1'b0;
          if (click_gap > 0) click_gap--;
          if (pending_clicks.size() == 0) stim_done = 1'b1;
        end
      end
    end
  end

  // monitor and output stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        jitter_t got, want;
        got = '{out_ch.chosen_offset, out_ch.window_mean, out_ch.deviation,
                out_ch.inlier_count, out_ch.inlier_mean};
        if (expected_jitter.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          errors++;
        end else begin
          want = expected_jitter.pop_front();
          if (got !== want) begin
            $display("%0t: expected %p actual %p", $time, want, got);
            errors++;
          end
        end
        stall_left = $urandom_range(0, 3);
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end
endmodule
